// ----- design/health_aware_round_robin_select_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the health-aware round-robin selector.
// ----------------------------------------------------------------------------
`ifndef HEALTH_AWARE_ROUND_ROBIN_SELECT_MACROS_SVH
`define HEALTH_AWARE_ROUND_ROBIN_SELECT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle.
`define HARRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("harrs assertion failed");

// Check that a condition implies another in the next cycle.
`define HARRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("harrs assertion failed");

`else

`define HARRS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HARRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/harrs_pkg.sv -----
// ----------------------------------------------------------------------------
// harrs_pkg
// Types and constants shared by the health-aware round-robin selector.
// ----------------------------------------------------------------------------
package harrs_pkg;

    localparam int ID_W     = 3;  // backend id width
    localparam int POS_W    = 3;  // stored list position width
    localparam int SLOT_W   = 4;  // member count, 0..8
    localparam int MEMBER_W = 8;  // membership mask width
    localparam int ROUTE_W  = 2;  // route select width
    localparam int NUM_CFG  = 4;  // membership registers

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_HEALTH = 1'b1;

    localparam logic [MEMBER_W-1:0] MEMBERS_RESET [NUM_CFG] = '{8'd3, 8'd4, 8'd7, 8'd0};

    typedef struct packed {
        logic clear;   // start a new search
        logic step;    // examine one backend
    } t_scan_ctl;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  slot;   // list slot of the chosen backend
        logic [SLOT_W-1:0] count;  // members seen so far
    } t_scan_res;

endpackage

// ----- design/harrs_scan.sv -----
// ----------------------------------------------------------------------------
// harrs_scan
// Shared search step: examines one backend per cycle while step is set, tracks
// its list slot and keeps the first healthy member at or past the start slot
// and the first healthy member before it.
// ----------------------------------------------------------------------------
module harrs_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  harrs_pkg::t_scan_ctl          i_ctl,
    input  logic                          i_member,
    input  logic                          i_healthy,
    input  logic [harrs_pkg::ID_W-1:0]    i_id,
    input  logic [harrs_pkg::POS_W-1:0]   i_start,
    output harrs_pkg::t_scan_res          o_res
);

    logic [harrs_pkg::SLOT_W-1:0] r_slot,    n_slot;
    logic                         r_hi_vld,  n_hi_vld;
    logic [harrs_pkg::ID_W-1:0]   r_hi_id,   n_hi_id;
    logic [harrs_pkg::POS_W-1:0]  r_hi_slot, n_hi_slot;
    logic                         r_lo_vld,  n_lo_vld;
    logic [harrs_pkg::ID_W-1:0]   r_lo_id,   n_lo_id;
    logic [harrs_pkg::POS_W-1:0]  r_lo_slot, n_lo_slot;
    logic                         w_past_start;

    assign w_past_start = (r_slot >= {1'b0, i_start});

    always_comb begin
        n_slot    = r_slot;
        n_hi_vld  = r_hi_vld;
        n_hi_id   = r_hi_id;
        n_hi_slot = r_hi_slot;
        n_lo_vld  = r_lo_vld;
        n_lo_id   = r_lo_id;
        n_lo_slot = r_lo_slot;
        if (i_ctl.clear) begin
            n_slot   = '0;
            n_hi_vld = 1'b0;
            n_lo_vld = 1'b0;
        end else if (i_ctl.step && i_member) begin
            // keep only the first hit in each half of the cyclic order
            if (i_healthy && w_past_start && !r_hi_vld) begin
                n_hi_vld  = 1'b1;
                n_hi_id   = i_id;
                n_hi_slot = r_slot[harrs_pkg::POS_W-1:0];
            end
            if (i_healthy && !w_past_start && !r_lo_vld) begin
                n_lo_vld  = 1'b1;
                n_lo_id   = i_id;
                n_lo_slot = r_slot[harrs_pkg::POS_W-1:0];
            end
            n_slot = r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_hi_vld <= 1'b0;
            r_lo_vld <= 1'b0;
        end else begin
            r_slot   <= n_slot;
            r_hi_vld <= n_hi_vld;
            r_lo_vld <= n_lo_vld;
        end
        r_hi_id   <= n_hi_id;
        r_hi_slot <= n_hi_slot;
        r_lo_id   <= n_lo_id;
        r_lo_slot <= n_lo_slot;
    end

    // a stale start leaves the upper half empty, so the lower hit wins
    always_comb begin
        o_res.found = r_hi_vld || r_lo_vld;
        o_res.id    = r_hi_vld ? r_hi_id   : (r_lo_vld ? r_lo_id   : '0);
        o_res.slot  = r_hi_vld ? r_hi_slot : r_lo_slot;
        o_res.count = r_slot;
    end

endmodule

// ----- design/health_aware_round_robin_select.sv -----
// ----------------------------------------------------------------------------
// health_aware_round_robin_select
// Per-route round-robin backend selector that skips unhealthy backends.
// ----------------------------------------------------------------------------
// A health request (tuser = 1) updates one backend's healthy bit in the cycle
// it is accepted and returns nothing; the next request can follow at once. A
// select request (tuser = 0) walks the backends one per cycle through a shared
// search step, and the input is not ready until its result is loaded into
// the result register. A select on a route at or above min(ROUTES, 4) skips
// the walk. A result waits in the output register until taken; health
// requests are still accepted meanwhile. Membership masks are to be written
// through the cfg port only while the block is idle; the block itself does
// not enforce this. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "health_aware_round_robin_select_macros.svh"

module health_aware_round_robin_select #(
    parameter int BACKENDS = 8,
    parameter int ROUTES   = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cfg write port
    input  logic                              i_cfg_we,
    input  logic [harrs_pkg::ROUTE_W-1:0]     i_cfg_index,
    input  logic [harrs_pkg::MEMBER_W-1:0]    i_cfg_data,
    // request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // route_select[1:0], backend_id[4:2], health_value[5]
    input  logic [0:0]                        i_s_axis_tuser,  // op[0]
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // chosen_backend[2:0]
    output logic [0:0]                        o_m_axis_tuser   // found[0]
);

    localparam int NB   = (BACKENDS < 8) ? BACKENDS : 8;
    localparam int NR   = (ROUTES < harrs_pkg::NUM_CFG) ? ROUTES : harrs_pkg::NUM_CFG;
    localparam int BI_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int RT_W = (NR > 1) ? $clog2(NR) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                              r_state, n_state;
    logic [harrs_pkg::MEMBER_W-1:0]      r_members [NR];
    logic [harrs_pkg::POS_W-1:0]         r_pos [NR];
    logic [NB-1:0]                       r_healthy;
    logic [harrs_pkg::MEMBER_W-1:0]      r_mask;
    logic [harrs_pkg::POS_W-1:0]         r_start;
    logic [harrs_pkg::ROUTE_W-1:0]       r_route;
    logic [harrs_pkg::ID_W-1:0]          r_id;
    logic                                r_out_valid;
    logic                                r_out_found;
    logic [harrs_pkg::ID_W-1:0]          r_out_id;

    logic                                w_in_acc;
    logic                                w_op;
    logic [harrs_pkg::ROUTE_W-1:0]       w_route;
    logic [harrs_pkg::ID_W-1:0]          w_bid;
    logic                                w_hv;
    logic                                w_route_ok;
    logic                                w_bid_ok;
    logic                                w_last_id;
    logic                                w_out_load;
    harrs_pkg::t_scan_ctl                w_ctl;
    harrs_pkg::t_scan_res                w_res;

    assign w_op    = i_s_axis_tuser[0];
    assign w_route = i_s_axis_tdata[1:0];
    assign w_bid   = i_s_axis_tdata[4:2];
    assign w_hv    = i_s_axis_tdata[5];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_route_ok      = ({1'b0, w_route} < 3'(NR));
    assign w_bid_ok        = ({1'b0, w_bid} < 4'(NB));
    assign w_last_id       = (r_id == harrs_pkg::ID_W'(NB - 1));
    assign w_out_load      = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    assign w_ctl.clear = w_in_acc && (w_op == harrs_pkg::OP_SELECT);
    assign w_ctl.step  = (r_state == ST_SCAN);

    harrs_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_member  (r_mask[r_id]),
        .i_healthy (r_healthy[r_id[BI_W-1:0]]),
        .i_id      (r_id),
        .i_start   (r_start),
        .o_res     (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_op == harrs_pkg::OP_SELECT)) begin
                    n_state = w_route_ok ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (w_last_id) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_healthy   <= '1;
            r_out_valid <= 1'b0;
            r_id        <= '0;
            for (int r = 0; r < NR; r++) begin
                r_members[r] <= harrs_pkg::MEMBERS_RESET[r];
                r_pos[r]     <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we && ({1'b0, i_cfg_index} < 3'(NR))) begin
                r_members[i_cfg_index[RT_W-1:0]] <= i_cfg_data;
            end

            if (w_in_acc && (w_op == harrs_pkg::OP_HEALTH) && w_bid_ok) begin
                r_healthy[w_bid[BI_W-1:0]] <= w_hv;
            end

            if (w_ctl.clear) begin
                r_id <= '0;
            end else if (r_state == ST_SCAN) begin
                r_id <= r_id + 1'b1;
            end

            // advance the route past the chosen slot, wrap at the list end
            if (w_out_load && w_res.found) begin
                if (({1'b0, w_res.slot} + 1'b1) == w_res.count) begin
                    r_pos[r_route[RT_W-1:0]] <= '0;
                end else begin
                    r_pos[r_route[RT_W-1:0]] <= w_res.slot + 1'b1;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_ctl.clear) begin
            r_route <= w_route;
            r_mask  <= w_route_ok ? r_members[w_route[RT_W-1:0]] : '0;
            r_start <= w_route_ok ? r_pos[w_route[RT_W-1:0]] : '0;
        end

        if (w_out_load) begin
            r_out_found <= w_res.found;
            r_out_id    <= w_res.id;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {{(8 - harrs_pkg::ID_W){1'b0}}, r_out_id};
    assign o_m_axis_tuser[0] = r_out_found;

    `HARRS_ASSERT_SAME(a_none_zero_id, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == 8'd0)
    `HARRS_ASSERT_SAME(a_pick_valid, i_clk, i_rst_n, (r_state == ST_DONE) && w_res.found, r_mask[w_res.id] && r_healthy[w_res.id[BI_W-1:0]])
    `HARRS_ASSERT_NEXT(a_select_scans, i_clk, i_rst_n, w_in_acc && (w_op == harrs_pkg::OP_SELECT) && w_route_ok, (r_state == ST_SCAN) && (r_id == '0))
    `HARRS_ASSERT_NEXT(a_result_written, i_clk, i_rst_n, w_out_load, o_m_axis_tvalid && (r_state == ST_IDLE))

endmodule

// ----- tb/health_aware_round_robin_select_test.sv -----
// ----------------------------------------------------------------------------
// health_aware_round_robin_select_test
// Self-checking bench for the per-route round-robin backend selector. It keeps
// its own copy of the route masks, backend health and round-robin positions,
// predicts the pick for every select request and compares each returned result
// in order. Directed cases come first, then random request streams over several
// route settings with random gaps on the request side and stalls on the result
// side.
// ----------------------------------------------------------------------------
module health_aware_round_robin_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic                       found;
        logic [harrs_pkg::ID_W-1:0] id;
    } t_pick;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [harrs_pkg::ROUTE_W-1:0]  i_cfg_index;
    logic [harrs_pkg::MEMBER_W-1:0] i_cfg_data;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    // route_select[1:0], backend_id[4:2], health_value[5]
    logic [7:0]                     i_s_axis_tdata;
    logic [0:0]                     i_s_axis_tuser;  // op[0]
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [7:0]                     o_m_axis_tdata;  // chosen_backend[2:0]
    logic [0:0]                     o_m_axis_tuser;  // found[0]

    health_aware_round_robin_select DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Shadow state of the selector
    logic [harrs_pkg::MEMBER_W-1:0] route_mask [harrs_pkg::NUM_CFG];
    logic [7:0]                     healthy_set;
    logic [harrs_pkg::POS_W-1:0]    rr_pos [harrs_pkg::NUM_CFG];

    t_pick pending_picks [$];

    logic sender_gaps;
    logic receiver_stalls;
    int   mismatches;
    int   n_selects;
    int   n_found;
    int   n_health;
    int   n_settings;
    int   quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cyclic search over the route's member list from its stored position
    function automatic t_pick pick_backend(input logic [harrs_pkg::ROUTE_W-1:0] route);
        logic [harrs_pkg::ID_W-1:0] member_list [8];
        int                         n;
        int                         start;
        int                         slot;
        t_pick                      pick;
        pick = '0;
        n = 0;
        for (int b = 0; b < 8; b++) begin
            if (route_mask[route][b]) begin
                member_list[n] = b[harrs_pkg::ID_W-1:0];
                n++;
            end
        end
        if (n == 0) return pick;
        // a rewritten mask may leave the position past the list end
        start = (int'(rr_pos[route]) >= n) ? 0 : int'(rr_pos[route]);
        for (int k = 0; k < n; k++) begin
            slot = start + k;
            if (slot >= n) slot -= n;
            if (healthy_set[member_list[slot]]) begin
                rr_pos[route] = (slot + 1 == n) ? '0 : harrs_pkg::POS_W'(slot + 1);
                pick.found = 1'b1;
                pick.id = member_list[slot];
                return pick;
            end
        end
        return pick;
    endfunction

    // Result side: random stall bursts
    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 17);
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // Compare each returned pick against the oldest prediction
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected result found=%0d id=%0d", $time,
                         o_m_axis_tuser[0], o_m_axis_tdata[2:0]);
                mismatches++;
            end else begin
                want = pending_picks.pop_front();
                if (o_m_axis_tuser[0] !== want.found || o_m_axis_tdata[2:0] !== want.id) begin
                    $display("%0t: expected found=%0d id=%0d, actual found=%0d id=%0d",
                             $time, want.found, want.id, o_m_axis_tuser[0],
                             o_m_axis_tdata[2:0]);
                    mismatches++;
                end else if (want.found) begin
                    n_found++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_picks.size());
            $display("health_aware_round_robin_select: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one request; valid stays high so a following request needs no toggle
    task automatic send_request(input logic op, input logic [harrs_pkg::ROUTE_W-1:0] route,
                                input logic [harrs_pkg::ID_W-1:0] bid, input logic hv);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, hv, bid, route};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (op == harrs_pkg::OP_SELECT) begin
            pending_picks.insert(pending_picks.size(), pick_backend(route));
            n_selects++;
        end else begin
            healthy_set[bid] = hv;
            n_health++;
        end
    endtask

    task automatic select_route(input logic [harrs_pkg::ROUTE_W-1:0] route);
        send_request(harrs_pkg::OP_SELECT, route, harrs_pkg::ID_W'($urandom), 1'($urandom));
    endtask

    task automatic set_health(input logic [harrs_pkg::ID_W-1:0] bid, input logic hv);
        send_request(harrs_pkg::OP_HEALTH, harrs_pkg::ROUTE_W'($urandom), bid, hv);
    endtask

    // Drop valid, wait for every pick to return, then let the block go quiet
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_routes(input logic [harrs_pkg::MEMBER_W-1:0] m0,
                                  input logic [harrs_pkg::MEMBER_W-1:0] m1,
                                  input logic [harrs_pkg::MEMBER_W-1:0] m2,
                                  input logic [harrs_pkg::MEMBER_W-1:0] m3);
        logic [harrs_pkg::MEMBER_W-1:0] masks [harrs_pkg::NUM_CFG];
        masks = '{m0, m1, m2, m3};
        for (int r = 0; r < harrs_pkg::NUM_CFG; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= harrs_pkg::ROUTE_W'(r);
            i_cfg_data  <= masks[r];
            @(posedge i_clk);
            route_mask[r] = masks[r];
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Reset masks: two-member, single-member, three-member and empty routes
    task automatic test_reset_masks;
        repeat (3) select_route(2'd0);
        select_route(2'd1);
        repeat (4) select_route(2'd2);
        select_route(2'd3);
    endtask

    // Skip unhealthy members, report none when all are down, then recover
    task automatic test_health_skip;
        set_health(3'd1, 1'b0);
        repeat (2) select_route(2'd0);
        set_health(3'd0, 1'b0);
        select_route(2'd0);
        select_route(2'd2);
        set_health(3'd7, 1'b0);
        set_health(3'd7, 1'b1);
        set_health(3'd0, 1'b1);
        set_health(3'd1, 1'b1);
        repeat (2) select_route(2'd0);
    endtask

    // Shrink a mask under an advanced position so the search restarts at slot 0
    task automatic test_stale_position;
        drain;
        program_routes(8'h01, 8'h80, 8'hFF, 8'hFF);
        repeat (5) select_route(2'd2);
        select_route(2'd3);
        drain;
        program_routes(8'h00, 8'h80, 8'h81, 8'hFF);
        repeat (2) select_route(2'd2);
        select_route(2'd0);
    endtask

    // Random streams over several route settings
    task automatic test_random_traffic;
        logic [harrs_pkg::MEMBER_W-1:0] m [harrs_pkg::NUM_CFG];
        for (int phase = 0; phase < 6; phase++) begin
            drain;
            case (phase)
                0: m = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                1: m = '{8'h00, 8'h80, 8'h01, 8'hFF};
                default: begin
                    for (int r = 0; r < harrs_pkg::NUM_CFG; r++) begin
                        m[r] = harrs_pkg::MEMBER_W'($urandom);
                    end
                end
            endcase
            program_routes(m[0], m[1], m[2], m[3]);
            for (int k = 0; k < 100; k++) begin
                if (phase == 5) begin
                    sender_gaps = 1'b0;
                    receiver_stalls = 1'b0;
                end else if (k % 25 == 0) begin
                    sender_gaps = 1'($urandom);
                    receiver_stalls = 1'($urandom);
                end
                if ($urandom_range(0, 9) < 6) begin
                    select_route(harrs_pkg::ROUTE_W'($urandom));
                end else begin
                    // lean toward healthy so picks are found most of the time
                    set_health(harrs_pkg::ID_W'($urandom), $urandom_range(0, 9) < 7);
                end
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        mismatches      = 0;
        n_selects       = 0;
        n_found         = 0;
        n_health        = 0;
        n_settings      = 1;
        quiet_cycles    = 0;
        for (int r = 0; r < harrs_pkg::NUM_CFG; r++) begin
            route_mask[r] = harrs_pkg::MEMBERS_RESET[r];
            rr_pos[r]     = '0;
        end
        healthy_set = 8'hFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_masks();
        test_health_skip();
        test_stale_position();
        test_random_traffic();
        drain();

        $display("Ran %0d select requests (%0d picked a backend) and %0d health updates",
                 n_selects, n_found, n_health);
        $display("over %0d route mask settings, %0d mismatches", n_settings, mismatches);
        if (mismatches == 0) begin
            $display("health_aware_round_robin_select: match");
        end else begin
            $display("health_aware_round_robin_select: mismatch");
        end
        $finish;
    end

endmodule
